### rtl/core/smc_pkg.sv
// Shared types and codes for the stack machine calculator
package smc_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int REG_IDX_W = 4;
    localparam int STATUS_W  = 2;

    // instruction codes
    localparam logic [MODE_W-1:0] MODE_PUSH_IMM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REG = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_REG  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUB      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MUL      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DIV      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_PRINT    = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [REG_IDX_W-1:0]     reg_index;
        logic signed [DATA_W-1:0] immediate;
    } smc_in_t;

    typedef struct packed {
        logic                     printed;
        logic signed [DATA_W-1:0] print_value;
        logic [STATUS_W-1:0]      status;
    } smc_out_t;

endpackage

### rtl/core/stack_machine_calculator_core.sv
// Stack machine calculator core: operand stack memory, register file and sequencer
//
// One instruction is taken at a time and yields exactly one result transfer.
// Push, pop, print, add, sub and mul go from transfer to result through operand
// read from the stack memory, execute and write back, and result load; divide
// waits on the one-bit-per-cycle divider before its write back and result load.
// A finished result sits in an output register, so the next instruction is
// taken as soon as the result is loaded, even if it is not yet taken.
// The operand stack is a synchronous memory read at the top two entries; the
// register file is a memory with per-entry valid bits that make unwritten
// registers read as zero right after reset, with no clearing pass.
module stack_machine_calculator_core #(
    parameter int STACK_DEPTH = 64,
    parameter int REG_COUNT   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  smc_pkg::smc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output smc_pkg::smc_out_t m_data
);
    import smc_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int RIX = RAW + REG_IDX_W;
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    smc_in_t           op_reg;
    smc_out_t          res_reg, res_next;
    logic              m_valid_reg;
    smc_out_t          m_data_reg;
    logic [REG_COUNT-1:0] reg_valid_reg;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] reg_mem [REG_COUNT];
    logic [DATA_W-1:0] top_q;
    logic [DATA_W-1:0] sec_q;
    logic [DATA_W-1:0] reg_q;
    logic              reg_valid_q;

    logic              accept;
    logic              out_free;
    logic [SPW-1:0]    sp_m1;
    logic [SPW-1:0]    sp_m2;
    logic [RIX-1:0]    in_ri_ext;
    logic [RIX-1:0]    op_ri_ext;
    logic              ri_ok;
    logic [DATA_W-1:0] reg_val;
    logic [DATA_W-1:0] arith_val;
    logic [DATA_W-1:0] mul_lo;

    logic              stack_we;
    logic [SAW-1:0]    stack_waddr;
    logic [DATA_W-1:0] stack_wdata;
    logic              reg_we;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);

    assign in_ri_ext = {RAW'(0), s_data.reg_index};
    assign op_ri_ext = {RAW'(0), op_reg.reg_index};
    assign ri_ok     = op_ri_ext < RIX'(REG_COUNT);
    assign reg_val   = (ri_ok && reg_valid_q) ? reg_q : '0;
    assign mul_lo    = sec_q * top_q;

    // operand stack memory, top two entries read on transfer
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (accept) begin
            top_q <= stack_mem[sp_m1[SAW-1:0]];
            sec_q <= stack_mem[sp_m2[SAW-1:0]];
        end
    end

    // register file memory
    always_ff @(posedge aclk) begin
        if (reg_we) begin
            reg_mem[op_ri_ext[RAW-1:0]] <= top_q;
        end
        if (accept) begin
            reg_q <= reg_mem[in_ri_ext[RAW-1:0]];
        end
    end

    // register valid bits, cleared at reset so registers read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_valid_reg <= '0;
            reg_valid_q   <= 1'b0;
        end else begin
            if (reg_we) begin
                reg_valid_reg[op_ri_ext[RAW-1:0]] <= 1'b1;
            end
            if (accept) begin
                reg_valid_q <= reg_valid_reg[in_ri_ext[RAW-1:0]];
            end
        end
    end

    // add, sub and mul of second (s) and top (t)
    always_comb begin
        case (op_reg.mode)
            MODE_ADD: arith_val = sec_q + top_q;
            MODE_SUB: arith_val = sec_q - top_q;
            default:  arith_val = mul_lo;
        endcase
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        res_next    = res_reg;
        stack_we    = 1'b0;
        stack_waddr = sp_m2[SAW-1:0];
        stack_wdata = arith_val;
        reg_we      = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next   = '0;
                state_next = ST_RESP;
                unique case (op_reg.mode) inside
                    MODE_PUSH_IMM, MODE_PUSH_REG: begin
                        if (sp_reg == SP_FULL) begin
                            res_next.status = STATUS_OVER;
                        end else begin
                            stack_we    = 1'b1;
                            stack_waddr = sp_reg[SAW-1:0];
                            stack_wdata = (op_reg.mode == MODE_PUSH_REG) ? reg_val
                                                                         : op_reg.immediate;
                            sp_next     = sp_reg + SPW'(1);
                        end
                    end
                    MODE_POP_REG, MODE_PRINT: begin
                        if (sp_reg == '0) begin
                            res_next.status = STATUS_UNDER;
                        end else begin
                            sp_next = sp_m1;
                            if (op_reg.mode == MODE_PRINT) begin
                                res_next.printed     = 1'b1;
                                res_next.print_value = top_q;
                            end else begin
                                reg_we = ri_ok;
                            end
                        end
                    end
                    default: begin
                        if (sp_reg < SPW'(2)) begin
                            res_next.status = STATUS_UNDER;
                        end else if (op_reg.mode == MODE_DIV) begin
                            if (top_q == '0) begin
                                res_next.status = STATUS_DIV_ZERO;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end else begin
                            stack_we = 1'b1;
                            sp_next  = sp_m1;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    stack_we    = 1'b1;
                    stack_wdata = div_q;
                    sp_next     = sp_m1;
                    state_next  = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            op_reg <= s_data;
        end
        if (state_reg == ST_RESP && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    smc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sec_q),
        .divisor  (top_q),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");
    a_print_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.printed |-> m_data_reg.print_value == '0)
        else $error("print value nonzero on non-print result");
    a_print_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.printed |-> m_data_reg.status == STATUS_OK)
        else $error("print flagged with error status");

endmodule

### rtl/core/smc_div.sv
// Iterative 32-bit signed divider, one quotient bit per cycle, truncating toward zero
module smc_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [smc_pkg::DATA_W-1:0] dividend,
    input  logic [smc_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [smc_pkg::DATA_W-1:0] quotient
);
    import smc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;

    // magnitudes of the operands
    assign num_mag = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    assign den_mag = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = ~diff[DATA_W];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den_mag;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], fits};
            end else if (neg_reg) begin
                quo_reg <= DATA_W'(0) - quo_reg;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // checks
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(start && busy_reg))
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not go busy after start");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule
